// File: src/fbh_pkg.sv
// fbh_pkg: shared types and constants for the fixed-bin histogram.
// Used by fbh_cfg, fbh_frac_div, the top level and the scoreboard; depends on nothing.
`default_nettype none
package fbh_pkg;

    localparam int DATA_W       = 32;
    localparam int NB_W         = 7;
    localparam int MAX_BINS_DEF = 64;
    localparam int CFG_ADDR_W   = 4;

    // register index, paddr[3:2]
    typedef enum logic [1:0] {
        REG_LOWER = 2'd0,
        REG_UPPER = 2'd1,
        REG_NBINS = 2'd2,
        REG_NONE  = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [DATA_W-1:0] lower_edge;
        logic [DATA_W-1:0] upper_edge;
        logic [NB_W-1:0]   num_bins;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_IDX,
        ST_RD,
        ST_WR,
        ST_CDIV,
        ST_CFIX,
        ST_BRD,
        ST_BMUL,
        ST_BDIV,
        ST_BOUT
    } state_t;

    function automatic logic [DATA_W-1:0] sat_inc(input logic [DATA_W-1:0] v);
        sat_inc = (v == '1) ? v : v + 1'b1;
    endfunction

endpackage
`default_nettype wire

// File: src/fbh_ram.sv
// fbh_ram: generic single-write, single-read RAM with registered read.
// Depends on nothing.
`default_nettype none
module fbh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// File: src/fbh_cfg.sv
// fbh_cfg: APB register file for the histogram edges and bin count.
// Depends on fbh_pkg.
`default_nettype none
module fbh_cfg
    import fbh_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready,
    output cfg_t                       cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lower_edge <= '0;
            cfg_reg.upper_edge <= 32'h0001_0000;
            cfg_reg.num_bins   <= NB_W'(64);
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_LOWER: cfg_reg.lower_edge <= pwdata;
                REG_UPPER: cfg_reg.upper_edge <= pwdata;
                REG_NBINS: cfg_reg.num_bins   <= pwdata[NB_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_LOWER: prdata = cfg_reg.lower_edge;
            REG_UPPER: prdata = cfg_reg.upper_edge;
            REG_NBINS: prdata = {{(32-NB_W){1'b0}}, cfg_reg.num_bins};
            default:   prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

// File: src/fbh_frac_div.sv
// fbh_frac_div: radix-2 divider giving floor(num * 2^32 / den), saturating.
// One quotient bit per cycle; depends on fbh_pkg.
`default_nettype none
module fbh_frac_div
    import fbh_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [63:0]       num,
    input  wire logic [63:0]       den,
    output logic                   done,
    output logic      [DATA_W-1:0] quot
);

    logic [63:0]       r_reg;
    logic [DATA_W-1:0] q_reg;
    logic [5:0]        cnt_reg;
    logic              run_reg;
    logic              done_reg;
    logic [63:0]       r_sh;
    logic              take;

    assign r_sh = {r_reg[62:0], 1'b0};
    assign take = r_reg[63] || (r_sh >= den);
    assign done = done_reg;
    assign quot = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                if (num >= den)
                begin
                    done_reg <= 1'b1;
                end
                else
                begin
                    run_reg <= 1'b1;
                    cnt_reg <= '0;
                end
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == 6'(DATA_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            r_reg <= num;
            q_reg <= (num >= den) ? '1 : '0;
        end
        else if (run_reg)
        begin
            r_reg <= take ? r_sh - den : r_sh;
            q_reg <= {q_reg[DATA_W-2:0], take};
        end
    end

endmodule
`default_nettype wire

// File: src/fixed_bin_histogram_density_top.sv
// Fixed-bin histogram with density readout: top level, control sequencer.
// Depends on fbh_pkg, fbh_cfg, fbh_ram and fbh_frac_div.
//
// Counts live in a MAX_BINS x 32 RAM with registered read; a valid bit per
// entry makes unwritten or cleared entries read as zero, so a readout clears
// all counts at once and no clearing pass follows reset. One item is
// processed at a time. An add item (tuser = 0) runs a multiply, a restoring
// divide one index bit per cycle, then a read-modify-write of the bin; a
// sample outside the range returns to idle after the multiply. A readout
// item (tuser = 1) first runs a serial divide for the bin spacing and a
// fixup step, then per bin a RAM read, a multiply and a 32-step density
// divide (skipped when every density is zero), plus any stall on the output.
// Results sit in an output register, so the next item is taken while the
// last bin still waits. The user must write configuration over APB at byte
// addresses 0, 4 and 8 only while idle; the block does not enforce it.
`default_nettype none
module fixed_bin_histogram_density_top
    import fbh_pkg::*;
#(
    parameter int MAX_BINS = MAX_BINS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // config
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready,
    // input items
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [31:0]           s_tdata,  // [31:0] sample
    input  wire logic [0:0]            s_tuser,  // [0] mode
    // result items
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [95:0]           m_tdata,  // [31:0] bin_center, [63:32] density,
                                                 // [95:64] bin_count
    output logic                       m_tlast   // last_bin
);

    localparam int IDX_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;

    cfg_t   cfg;
    state_t state_reg, state_next;

    // config-derived values
    logic [NB_W-1:0]   nb;
    logic [7:0]        m2;        // 2 * bins
    logic signed [32:0] w;
    logic [32:0]       w_mag;
    logic              w_pos;

    // add path
    logic [DATA_W-1:0] samp_reg;
    logic signed [32:0] d;
    logic              in_rng;
    logic [38:0]       rem_reg;
    logic [38:0]       w_sh;
    logic [2:0]        k_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              idx_bit;

    // shared
    logic [DATA_W-1:0] total_reg;
    logic [MAX_BINS-1:0] valid_reg;
    logic [IDX_W-1:0]  raddr;
    logic [DATA_W-1:0] rdata;
    logic [DATA_W-1:0] cnt_rd;

    // readout path
    logic [32:0]       sh_reg;
    logic [7:0]        cr_reg;
    logic [5:0]        step_reg;
    logic [8:0]        cdiv_sh;
    logic              cdiv_take;
    logic [DATA_W-1:0] qa;
    logic [7:0]        ra;
    logic [8:0]        two_ra;
    logic [DATA_W-1:0] cq_reg;
    logic [DATA_W-1:0] stepq_reg;
    logic [7:0]        stepr_reg;
    logic [8:0]        csum;
    logic [NB_W-1:0]   bin_reg;
    logic [DATA_W-1:0] c_reg;
    logic [63:0]       den_reg;
    logic [63:0]       num;
    logic              dens_ok_reg;
    logic              is_last;
    logic              div_done;
    logic [DATA_W-1:0] div_q;

    // output register
    logic              m_tvalid_reg;
    logic [95:0]       m_tdata_reg;
    logic              m_tlast_reg;
    logic              out_free;

    // control strobes
    logic              in_acc;
    logic              ram_we;
    logic              div_start;
    logic              out_load;

    fbh_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    always_comb
    begin
        priority if (cfg.num_bins == '0)
            nb = NB_W'(1);
        else if (cfg.num_bins > NB_W'(MAX_BINS))
            nb = NB_W'(MAX_BINS);
        else
            nb = cfg.num_bins;
    end

    assign m2    = {nb, 1'b0};
    assign w     = $signed({cfg.upper_edge[31], cfg.upper_edge})
                 - $signed({cfg.lower_edge[31], cfg.lower_edge});
    assign w_mag = w[32] ? 33'(-w) : w;
    assign w_pos = !w[32] && (w != '0);

    // add path datapath
    assign d       = $signed({samp_reg[31], samp_reg})
                   - $signed({cfg.lower_edge[31], cfg.lower_edge});
    assign in_rng  = w_pos && !d[32] && (d[31:0] < w[31:0]);
    assign w_sh    = {7'b0, w[31:0]} << k_reg;
    assign idx_bit = rem_reg >= w_sh;

    // bin address held through the cycle that sees the read data
    assign raddr  = (state_reg == ST_BRD || state_reg == ST_BMUL) ?
                    bin_reg[IDX_W-1:0] : idx_reg;
    assign cnt_rd = valid_reg[raddr] ? rdata : '0;

    fbh_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_BINS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (sat_inc(cnt_rd)),
        .raddr (raddr),
        .rdata (rdata)
    );

    // half bin spacing: floor(w / 2B) by serial divide of |w|, then signed fixup
    assign cdiv_sh   = {cr_reg, sh_reg[32]};
    assign cdiv_take = cdiv_sh >= {1'b0, m2};

    always_comb
    begin
        if (w[32])
        begin
            qa = -sh_reg[31:0] - ((cr_reg != '0) ? 32'd1 : 32'd0);
            ra = (cr_reg != '0) ? m2 - cr_reg : '0;
        end
        else
        begin
            qa = sh_reg[31:0];
            ra = cr_reg;
        end
    end

    assign two_ra  = {ra, 1'b0};
    assign csum    = {1'b0, cr_reg} + {1'b0, stepr_reg};
    assign is_last = (bin_reg == nb - 1'b1);
    // count * bins, taken straight from the RAM read in ST_BMUL
    assign num     = {32'b0, cnt_rd} * {57'b0, nb};

    fbh_frac_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num),
        .den   (den_reg),
        .done  (div_done),
        .quot  (div_q)
    );

    assign out_free = !m_tvalid_reg || m_tready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_tvalid) state_next = s_tuser[0] ? ST_CDIV : ST_MUL;
            ST_MUL:  state_next = in_rng ? ST_IDX : ST_IDLE;
            ST_IDX:  if (k_reg == '0) state_next = ST_RD;
            ST_RD:   state_next = ST_WR;
            ST_WR:   state_next = ST_IDLE;
            ST_CDIV: if (step_reg == 6'd32) state_next = ST_CFIX;
            ST_CFIX: state_next = ST_BRD;
            ST_BRD:  state_next = ST_BMUL;
            ST_BMUL: state_next = dens_ok_reg ? ST_BDIV : ST_BOUT;
            ST_BDIV: if (div_done) state_next = ST_BOUT;
            ST_BOUT: if (out_free) state_next = is_last ? ST_IDLE : ST_BRD;
            default: state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        s_tready  = (state_reg == ST_IDLE);
        in_acc    = s_tready && s_tvalid;
        ram_we    = (state_reg == ST_WR) && ({{(NB_W-IDX_W){1'b0}}, idx_reg} < nb);
        div_start = (state_reg == ST_BMUL) && dens_ok_reg;
        out_load  = (state_reg == ST_BOUT) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            total_reg    <= '0;
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_acc && !s_tuser[0])
            begin
                total_reg <= sat_inc(total_reg);
            end
            if (ram_we)
            begin
                valid_reg[idx_reg] <= 1'b1;
            end
            if (out_load && is_last)
            begin
                valid_reg <= '0;
                total_reg <= '0;
            end
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                samp_reg    <= s_tdata;
                sh_reg      <= w_mag;
                cr_reg      <= '0;
                step_reg    <= '0;
                den_reg     <= total_reg * {32'b0, w[31:0]};
                dens_ok_reg <= w_pos && (total_reg != '0);
                bin_reg     <= '0;
            end
            ST_MUL:
            begin
                rem_reg <= {7'b0, d[31:0]} * {32'b0, nb};
                k_reg   <= 3'(IDX_W - 1);
                idx_reg <= '0;
            end
            ST_IDX:
            begin
                if (idx_bit)
                begin
                    rem_reg <= rem_reg - w_sh;
                end
                idx_reg <= IDX_W'({idx_reg, idx_bit});
                k_reg   <= k_reg - 1'b1;
            end
            ST_CDIV:
            begin
                // 33 steps, one per bit of |w|
                sh_reg   <= {sh_reg[31:0], cdiv_take};
                cr_reg   <= cdiv_take ? 8'(cdiv_sh - {1'b0, m2}) : cdiv_sh[7:0];
                step_reg <= step_reg + 1'b1;
            end
            ST_CFIX:
            begin
                cq_reg <= qa;
                cr_reg <= ra;
                if (two_ra >= {1'b0, m2})
                begin
                    stepq_reg <= {qa[30:0], 1'b1};
                    stepr_reg <= 8'(two_ra - {1'b0, m2});
                end
                else
                begin
                    stepq_reg <= {qa[30:0], 1'b0};
                    stepr_reg <= two_ra[7:0];
                end
            end
            ST_BMUL:
            begin
                c_reg <= cnt_rd;
            end
            ST_BOUT:
            begin
                if (out_free)
                begin
                    bin_reg <= bin_reg + 1'b1;
                    if (csum >= {1'b0, m2})
                    begin
                        cr_reg <= 8'(csum - {1'b0, m2});
                        cq_reg <= cq_reg + stepq_reg + 1'b1;
                    end
                    else
                    begin
                        cr_reg <= csum[7:0];
                        cq_reg <= cq_reg + stepq_reg;
                    end
                end
            end
            default: ;
        endcase

        if (out_load)
        begin
            m_tdata_reg <= {c_reg,
                            dens_ok_reg ? div_q : 32'd0,
                            cfg.lower_edge + cq_reg};
            m_tlast_reg <= is_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule
`default_nettype wire

// File: src/fbh_checker.sv
// fbh_checker: port-level assertions for the histogram top level.
// Bound to fixed_bin_histogram_density_top; depends on nothing else.
`default_nettype none
module fbh_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [0:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [95:0] m_tdata,
    input wire logic        m_tlast
);

    // one item at a time: input closes right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while previous item in progress");

    // readout input is still closed partway into the spacing divide
    a_readout_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser[0] |-> ##2 !s_tready)
        else $error("readout finished too early");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

endmodule

bind fixed_bin_histogram_density_top fbh_checker u_fbh_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
`default_nettype wire

// File: tb/sv/fbh_checker.sv
// fbh_scoreboard: watches the item and result streams of the fixed-bin histogram,
// predicts every readout bin and compares it. Depends on fbh_pkg.
`timescale 1ns / 100ps
module fbh_scoreboard
    import fbh_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [31:0] s_tdata,
    input  wire logic [0:0]  s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [95:0] m_tdata,
    input  wire logic        m_tlast,
    output int               fail_count,
    output int               pending
);

    typedef struct packed {
        logic [31:0] center;
        logic [31:0] dens;
        logic [31:0] count;
        logic        last;
    } bin_result_t;

    bin_result_t want_q[$];
    logic [31:0] lo_edge, hi_edge;
    logic [6:0]  nbins_reg;
    logic [31:0] counts[64];
    logic [31:0] total;

    // floor(n * 2^32 / d), saturated
    function automatic logic [31:0] density_of(input logic [63:0] n, input logic [63:0] d);
        logic [127:0] q;
        if (n >= d) return 32'hFFFF_FFFF;
        q = ({64'd0, n} << 32) / {64'd0, d};
        return q[31:0];
    endfunction

    task automatic take_item(input logic mode, input logic [31:0] x);
        int          nb;
        longint      lo, w, d, num, off;
        longint unsigned idx;
        bin_result_t r;
        nb = (nbins_reg == 0) ? 1 : (nbins_reg > 64 ? 64 : int'(nbins_reg));
        lo = longint'($signed(lo_edge));
        w  = longint'($signed(hi_edge)) - lo;
        if (!mode) begin
            d = longint'($signed(x)) - lo;
            if (total != '1) total++;
            if (w > 0 && d >= 0) begin
                idx = longint'(d * nb) / w;
                if (idx < nb && counts[idx] != '1) counts[idx]++;
            end
            return;
        end
        for (int i = 0; i < nb; i++) begin
            num = (2 * i + 1) * w;
            off = num / (2 * nb);
            if (num % (2 * nb) != 0 && num < 0) off--;
            r.center = 32'(lo + off);
            r.count  = counts[i];
            r.dens   = (w > 0 && total != 0) ?
                       density_of(64'(counts[i]) * nb, 64'(total) * 64'(w)) : '0;
            r.last   = (i == nb - 1);
            want_q.push_back(r);
        end
        foreach (counts[k]) counts[k] = '0;
        total = '0;
    endtask

    always @(posedge clk or negedge rst_n) begin
        bin_result_t want;
        if (!rst_n) begin
            lo_edge    <= '0;
            hi_edge    <= 32'd65536;
            nbins_reg  <= 7'd64;
            total       = '0;
            foreach (counts[k]) counts[k] = '0;
            fail_count <= 0;
            pending    <= 0;
        end else begin
            if (psel && penable && pwrite) begin
                case (reg_idx_t'(paddr[3:2]))
                    REG_LOWER: lo_edge   <= pwdata;
                    REG_UPPER: hi_edge   <= pwdata;
                    REG_NBINS: nbins_reg <= pwdata[6:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (want_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("ERROR: unexpected bin %h last %b", m_tdata, m_tlast);
                    fail_count <= fail_count + 1;
                end else begin
                    want = want_q.pop_front();
                    if (m_tdata[31:0] !== want.center || m_tdata[63:32] !== want.dens ||
                        m_tdata[95:64] !== want.count || m_tlast !== want.last) begin
                        if (fail_count < 10)
                            $display("ERROR: bin exp c=%h d=%h n=%h l=%b got c=%h d=%h n=%h l=%b",
                                     want.center, want.dens, want.count, want.last,
                                     m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tlast);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_tvalid && s_tready) take_item(s_tuser[0], s_tdata);
            pending <= want_q.size();
        end
    end

endmodule

// File: tb/sv/tb.sv
// tb: stimulus and verdict for fixed_bin_histogram_density_top.
// Depends on fbh_pkg, the block RTL and fbh_scoreboard.
`timescale 1ns / 100ps
module tb;
    import fbh_pkg::*;

    logic        clk = 0, rst_n = 0;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0, prdata;
    logic        pready;
    logic        s_tvalid = 0, s_tready;
    logic [31:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid, m_tready = 0, m_tlast;
    logic [95:0] m_tdata;
    int          fail_count, pending;
    int          send_idle = 0, recv_idle = 0;
    logic        hold_off = 0;
    longint      cycles = 0;

    always #5 clk = ~clk;

    fixed_bin_histogram_density_top dut (.*);
    fbh_scoreboard chk (.*);

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > 4_000_000) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge clk)
        m_tready <= !hold_off && ($urandom_range(99) >= recv_idle);

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] v);
        psel <= 1; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= v;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        @(posedge clk);
    endtask

    task automatic send(input logic mode, input logic [31:0] x);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 0;
            @(posedge clk);
        end
        s_tvalid <= 1; s_tuser <= mode; s_tdata <= x;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic set_range(input logic [31:0] lo, input logic [31:0] hi,
                             input logic [6:0] nb);
        write_reg(REG_LOWER, lo);
        write_reg(REG_UPPER, hi);
        write_reg(REG_NBINS, {25'd0, nb});
    endtask

    // sample near the range most of the time, anything otherwise
    function automatic logic [31:0] pick_sample(input logic [31:0] lo, input logic [31:0] hi);
        longint l, h;
        l = $signed(lo); h = $signed(hi);
        if ($urandom_range(9) == 0 || h <= l) return $urandom;
        return 32'(l - (h - l) / 8 + longint'($urandom) % ((h - l) * 5 / 4 + 1));
    endfunction

    initial begin
        logic [31:0] lo, hi;
        int          n;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed, reset config
        send(0, 32'h0000_0000); send(0, 32'h0000_FFFF); send(0, 32'h0001_0000);
        send(0, 32'hFFFF_FFFF); send(0, 32'h8000_0000); send(0, 32'h7FFF_FFFF);
        send(0, 32'h0000_8000); send(1, $urandom);
        send(1, '0);  // empty total
        drain();
        set_range(32'h8000_0000, 32'h7FFF_FFFF, 7'd1);
        send(0, 32'h8000_0000); send(0, 32'h7FFF_FFFF); send(0, 32'h7FFF_FFFE);
        send(1, '0);
        drain();
        set_range(32'h0001_0000, 32'h0001_0000, 7'd0);  // empty range, bins 0
        send(0, 32'h0001_0000); send(1, '0);
        drain();
        set_range(32'h0002_0000, 32'hFFFF_0000, 7'd127);  // inverted, bins clamp
        send(0, 32'h0000_0000); send(1, '0);
        drain();

        // random phases
        for (int ph = 0; ph < 9; ph++) begin
            send_idle = (ph < 3) ? 8 : (ph < 6 ? 86 : 0);
            recv_idle = (ph < 3) ? 86 : (ph < 6 ? 8 : 0);
            lo = $urandom; hi = $urandom;
            if ($signed(hi) < $signed(lo)) {lo, hi} = {hi, lo};
            if (ph == 8) begin lo = 32'h8000_0000; hi = 32'h7FFF_FFFF; end
            if (ph == 0) begin lo = 32'hFFFF_0000; hi = 32'h0001_0000; end
            n = (ph == 8 || ph == 4) ? 64 :
                ($urandom_range(3) == 0 ? 64 : $urandom_range(1, 6));
            set_range(lo, hi, 7'(n));
            for (int i = 0; i < 34; i++) begin
                if ($urandom_range(9) == 0) send(1, $urandom);
                else send(0, pick_sample(lo, hi));
                if (ph == 4 && i == 20) begin
                    // receiver stalls while items keep coming
                    hold_off = 1;
                    fork
                        begin
                            repeat (400) @(posedge clk);
                            hold_off = 0;
                        end
                    join_none
                    send(1, '0); send(0, '0); send(0, '1);
                    send(0, lo);
                end
            end
            send(1, '0);
            drain();
        end

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: filelist.f
src/fbh_pkg.sv
src/fbh_ram.sv
src/fbh_cfg.sv
src/fbh_frac_div.sv
src/fixed_bin_histogram_density_top.sv
src/fbh_checker.sv
tb/sv/fbh_checker.sv
tb/sv/tb.sv
